/* hw/rtl/fpea_pkg.sv */
// ----------------------------------------------------------------------------
// Flash partition extent allocator package
// Shared types, codes and a helper function for the allocator and its table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpea_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int NAME_BYTES  = 8;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Label of the self entry: "ptable" packed first byte lowest.
	localparam logic [63:0] SELF_LABEL = 64'h0000_656C_6261_7470;

	// Command codes.
	localparam logic [2:0] CMD_CREATE   = 3'd0;
	localparam logic [2:0] CMD_ADD      = 3'd1;
	localparam logic [2:0] CMD_REMOVE   = 3'd2;
	localparam logic [2:0] CMD_FIND     = 3'd3;
	localparam logic [2:0] CMD_ALLOC    = 3'd4;
	localparam logic [2:0] CMD_ALLOC_AT = 3'd5;

	// Status codes.
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_INVALID     = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND   = 3'd2;
	localparam logic [2:0] STAT_EXISTS      = 3'd3;
	localparam logic [2:0] STAT_NOT_ALLOWED = 3'd4;
	localparam logic [2:0] STAT_FULL        = 3'd5;

	// Configuration register indexes.
	localparam logic REG_FLASH_LENGTH = 1'b0;
	localparam logic REG_PAGE_SHIFT   = 1'b1;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic [31:0] flags;
		logic [63:0] label;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           entry;
	} tbl_wr_t;

	typedef struct packed {
		logic [63:0] label;
		logic [3:0]  len;
	} name_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_SUM,
		S_LOC,
		S_CHECK,
		S_OVL,
		S_FINAL,
		S_SHIFT_UP,
		S_INSERT,
		S_SHIFT_DN,
		S_GAP,
		S_GAP_END,
		S_FREE,
		S_RESP
	} fpea_state_t;

	// Keeps the name bytes up to the first zero byte and counts them.
	function automatic name_t clean_name(input logic [63:0] raw);
		name_t r;
		logic  stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (raw[8*i +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r.label[8*i +: 8] = raw[8*i +: 8];
				r.len             = r.len + 4'd1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/fpea_table.sv */
// ----------------------------------------------------------------------------
// Partition table storage
// Sixteen entries with one write port and one read port chosen by index.
// ----------------------------------------------------------------------------
`default_nettype none

module fpea_table (
	input  wire logic             clk,
	input  wire fpea_pkg::tbl_wr_t wr,
	input  wire logic [fpea_pkg::IDX_W-1:0] rd_idx,
	output fpea_pkg::entry_t      rd_entry
);

	fpea_pkg::entry_t entries_q [fpea_pkg::MAX_ENTRIES];

	// Write port; the entries carry no reset and are read only below the count.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			entries_q[wr.idx] <= wr.entry;
		end
	end

	// Read port.
	assign rd_entry = entries_q[rd_idx];

endmodule

`default_nettype wire

/* hw/rtl/flash_partition_extent_allocator_top.sv */
// ----------------------------------------------------------------------------
// Flash partition extent allocator
// Sorted partition table with first-fit and last-fit extent allocation.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result. After the accepting
// edge a command rounds the size up to a page in S_PREP and forms the end
// sums in S_SUM. It then walks the sorted table one entry per cycle
// through the single table read port, and last loads the result register.
// The shift-down of a remove takes the place of the rest of its scan. Add
// scans the table twice; the entries it moves up to open its slot take the
// place of the rest of its overlap scan. A command refused before the scan
// goes from S_SUM straight to the result. The result sits in an output
// register, so the next command may be taken while it waits. A finished
// command holds its result back only while the previous one is still unread.
`default_nettype none

module flash_partition_extent_allocator_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write channel.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	// Command stream.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: part_name[63:0], start_offset[95:64], size_bytes[127:96],
	// part_flags[159:128]
	input  wire logic [159:0] s_axis_tdata,
	// tuser: cmd[2:0], at_end[3]
	input  wire logic [3:0]   s_axis_tuser,
	// Result stream.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: result_offset[31:0], result_length[63:32], result_flags[95:64]
	output logic [95:0]       m_axis_tdata,
	// tuser: status[2:0]
	output logic [2:0]        m_axis_tuser
);

	localparam int CW = fpea_pkg::CNT_W;
	localparam int IW = fpea_pkg::IDX_W;

	fpea_pkg::fpea_state_t state_q, state_d;

	logic [31:0]    flash_len_q;
	logic [4:0]     page_shift_q;
	logic           valid_q;
	logic [CW-1:0]  count_q;
	logic           m_valid_q;

	logic [2:0]     cmd_q;
	logic [63:0]    label_q;
	logic [3:0]     nlen_q;
	logic [31:0]    off_q, len_q, flags_q;
	logic           at_end_q;
	logic [32:0]    rlen_q, sum_q, endr_q, last_end_q;
	logic [CW-1:0]  idx_q, pos_q;
	logic           found_q;
	logic [31:0]    r_off_q, r_len_q, r_flags_q;
	logic [2:0]     status_q;
	logic [95:0]    m_data_q;
	logic [2:0]     m_user_q;

	logic           fin;
	logic [2:0]     fin_st;
	logic           in_acc, resp_go;

	fpea_pkg::tbl_wr_t wr;
	logic [IW-1:0]     rd_idx;
	fpea_pkg::entry_t  rd;
	fpea_pkg::name_t   in_name;

	fpea_table u_table (
		.clk      (clk),
		.wr       (wr),
		.rd_idx   (rd_idx),
		.rd_entry (rd)
	);

	// Page arithmetic from the current page shift.
	logic [32:0] page_b, page_m;
	assign page_b = 33'd1 << page_shift_q;
	assign page_m = page_b - 33'd1;

	assign in_name = fpea_pkg::clean_name(s_axis_tdata[63:0]);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign resp_go = (state_q == fpea_pkg::S_RESP) && (!m_valid_q || m_axis_tready);

	// End of the rounded extent, formed while the sums are taken.
	logic [32:0] endr_d;
	assign endr_d = {1'b0, off_q} + rlen_q;

	// Comparisons against the entry under the scan index.
	logic [32:0] e_start, e_end, lo, fl33, gap;
	logic [33:0] tail_sum;
	logic        at_count, label_hit, ovl, gap_ok, tail_ok, clash, too_long, is_add;
	assign e_start   = {1'b0, rd.start};
	assign e_end     = {1'b0, rd.start} + {1'b0, rd.size};
	assign fl33      = {1'b0, flash_len_q};
	assign lo        = (idx_q == '0) ? 33'd0 : last_end_q;
	assign gap       = e_start - lo;
	assign at_count  = (idx_q == count_q);
	assign label_hit = (rd.label == label_q);
	assign ovl       = (({1'b0, off_q} >= e_start) && ({1'b0, off_q} < e_end))
	                || ((endr_q > e_start) && (endr_q <= e_end))
	                || (({1'b0, off_q} < e_start) && (endr_q > e_end));
	assign gap_ok    = (e_start >= lo) && (gap >= rlen_q);
	assign tail_sum  = {1'b0, last_end_q} + {1'b0, rlen_q};
	assign tail_ok   = (tail_sum <= {2'b00, flash_len_q});
	assign clash     = ((e_start < {1'b0, off_q}) && (e_end > {1'b0, off_q}))
	                || ((e_start >= {1'b0, off_q}) && (e_start < endr_q));
	assign too_long  = (32'(nlen_q) >= 32'(fpea_pkg::NAME_BYTES));
	assign is_add    = (cmd_q == fpea_pkg::CMD_ADD) || (cmd_q == fpea_pkg::CMD_CREATE);

	logic [31:0] s_minus_need, fl_minus_need;
	logic [32:0] s_diff, fl_diff;
	assign s_diff        = e_start - rlen_q;
	assign fl_diff       = fl33 - rlen_q;
	assign s_minus_need  = s_diff[31:0];
	assign fl_minus_need = fl_diff[31:0];

	logic [CW-1:0] idx_dec, idx_inc;
	assign idx_dec = idx_q - CW'(1);
	assign idx_inc = idx_q + CW'(1);

	// Next state and the status that finishes a command.
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		fin_st  = fpea_pkg::STAT_INVALID;
		case (state_q)
			fpea_pkg::S_IDLE: begin
				if (in_acc) state_d = fpea_pkg::S_PREP;
			end
			fpea_pkg::S_PREP: state_d = fpea_pkg::S_SUM;
			fpea_pkg::S_SUM: begin
				case (cmd_q)
					fpea_pkg::CMD_CREATE, fpea_pkg::CMD_ADD: begin
						if (!valid_q || too_long) fin = 1'b1;
						else state_d = fpea_pkg::S_LOC;
					end
					fpea_pkg::CMD_REMOVE: begin
						if (!valid_q) begin
							fin = 1'b1;
						end else if (label_q == fpea_pkg::SELF_LABEL) begin
							fin    = 1'b1;
							fin_st = fpea_pkg::STAT_NOT_ALLOWED;
						end else begin
							state_d = fpea_pkg::S_LOC;
						end
					end
					fpea_pkg::CMD_FIND: begin
						if (!valid_q) begin
							fin    = 1'b1;
							fin_st = fpea_pkg::STAT_NOT_FOUND;
						end else begin
							state_d = fpea_pkg::S_LOC;
						end
					end
					fpea_pkg::CMD_ALLOC: begin
						if (!valid_q) fin = 1'b1;
						else state_d = fpea_pkg::S_GAP;
					end
					fpea_pkg::CMD_ALLOC_AT: begin
						if (!valid_q || endr_d[32] || (endr_d > fl33)) fin = 1'b1;
						else state_d = fpea_pkg::S_FREE;
					end
					default: fin = 1'b1;
				endcase
			end
			fpea_pkg::S_LOC: begin
				if (at_count) begin
					if (is_add) begin
						state_d = fpea_pkg::S_CHECK;
					end else begin
						fin    = 1'b1;
						fin_st = fpea_pkg::STAT_NOT_FOUND;
					end
				end else if (label_hit) begin
					case (cmd_q)
						fpea_pkg::CMD_FIND: begin
							fin    = 1'b1;
							fin_st = fpea_pkg::STAT_OK;
						end
						fpea_pkg::CMD_REMOVE: state_d = fpea_pkg::S_SHIFT_DN;
						default: begin
							fin    = 1'b1;
							fin_st = fpea_pkg::STAT_EXISTS;
						end
					endcase
				end
			end
			fpea_pkg::S_CHECK: begin
				if ((off_q & page_m[31:0]) != '0) fin = 1'b1;
				else if ((len_q == '0) || sum_q[32]) fin = 1'b1;
				else if (sum_q > fl33) fin = 1'b1;
				else state_d = fpea_pkg::S_OVL;
			end
			fpea_pkg::S_OVL: begin
				if (at_count) state_d = fpea_pkg::S_FINAL;
				else if (ovl) fin = 1'b1;
				else if (endr_q <= e_start) state_d = fpea_pkg::S_FINAL;
			end
			fpea_pkg::S_FINAL: begin
				if (32'(count_q) >= 32'(fpea_pkg::MAX_ENTRIES)) begin
					fin    = 1'b1;
					fin_st = fpea_pkg::STAT_FULL;
				end else if (endr_q > fl33) begin
					fin = 1'b1;
				end else if (pos_q == count_q) begin
					state_d = fpea_pkg::S_INSERT;
				end else begin
					state_d = fpea_pkg::S_SHIFT_UP;
				end
			end
			fpea_pkg::S_SHIFT_UP: begin
				if (idx_dec == pos_q) state_d = fpea_pkg::S_INSERT;
			end
			fpea_pkg::S_INSERT: begin
				fin    = 1'b1;
				fin_st = fpea_pkg::STAT_OK;
			end
			fpea_pkg::S_SHIFT_DN: begin
				if (!(idx_inc < count_q)) begin
					fin    = 1'b1;
					fin_st = fpea_pkg::STAT_OK;
				end
			end
			fpea_pkg::S_GAP: begin
				if (at_count) state_d = fpea_pkg::S_GAP_END;
				else if (gap_ok && !at_end_q) begin
					fin    = 1'b1;
					fin_st = fpea_pkg::STAT_OK;
				end
			end
			fpea_pkg::S_GAP_END: begin
				fin    = 1'b1;
				fin_st = (found_q || tail_ok) ? fpea_pkg::STAT_OK : fpea_pkg::STAT_NOT_FOUND;
			end
			fpea_pkg::S_FREE: begin
				if (at_count) begin
					fin    = 1'b1;
					fin_st = fpea_pkg::STAT_OK;
				end else if (clash) begin
					fin    = 1'b1;
					fin_st = fpea_pkg::STAT_NOT_FOUND;
				end
			end
			fpea_pkg::S_RESP: begin
				if (resp_go) state_d = fpea_pkg::S_IDLE;
			end
			default: state_d = fpea_pkg::S_IDLE;
		endcase
		if (fin) state_d = fpea_pkg::S_RESP;
	end

	// Handshake outputs and the table ports.
	always_comb begin
		s_axis_tready = (state_q == fpea_pkg::S_IDLE);
		cfg_ready     = 1'b1;
		rd_idx        = idx_q[IW-1:0];
		wr.en         = 1'b0;
		wr.idx        = idx_q[IW-1:0];
		wr.entry      = rd;
		case (state_q)
			fpea_pkg::S_SHIFT_UP: begin
				rd_idx = idx_dec[IW-1:0];
				wr.en  = 1'b1;
			end
			fpea_pkg::S_SHIFT_DN: begin
				rd_idx = idx_inc[IW-1:0];
				wr.en  = (idx_inc < count_q);
			end
			fpea_pkg::S_INSERT: begin
				wr.en          = 1'b1;
				wr.idx         = pos_q[IW-1:0];
				wr.entry.start = off_q;
				wr.entry.size  = rlen_q[31:0];
				wr.entry.flags = flags_q;
				wr.entry.label = label_q;
			end
			default: ;
		endcase
	end

	// Control state: sequencer, configuration, table status and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fpea_pkg::S_IDLE;
			flash_len_q  <= 32'd1048576;
			page_shift_q <= 5'd12;
			valid_q      <= 1'b0;
			count_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fpea_pkg::REG_FLASH_LENGTH: flash_len_q  <= cfg_data;
					fpea_pkg::REG_PAGE_SHIFT:   page_shift_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_acc && (s_axis_tuser[2:0] == fpea_pkg::CMD_CREATE)) begin
				valid_q <= 1'b1;
				count_q <= '0;
			end
			if (state_q == fpea_pkg::S_INSERT) begin
				count_q <= count_q + CW'(1);
			end
			if ((state_q == fpea_pkg::S_SHIFT_DN) && fin) begin
				count_q <= count_q - CW'(1);
			end
			if (fin && (cmd_q == fpea_pkg::CMD_CREATE) && (fin_st != fpea_pkg::STAT_OK)) begin
				valid_q <= 1'b0;
			end
			if (resp_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the command being worked on.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q     <= s_axis_tuser[2:0];
			at_end_q  <= s_axis_tuser[3];
			r_off_q   <= '0;
			r_len_q   <= '0;
			r_flags_q <= '0;
			if (s_axis_tuser[2:0] == fpea_pkg::CMD_CREATE) begin
				label_q <= fpea_pkg::SELF_LABEL;
				nlen_q  <= 4'd6;
				off_q   <= flash_len_q - page_b[31:0];
				len_q   <= page_b[31:0];
				flags_q <= '0;
			end else begin
				label_q <= in_name.label;
				nlen_q  <= in_name.len;
				off_q   <= s_axis_tdata[95:64];
				len_q   <= s_axis_tdata[127:96];
				flags_q <= s_axis_tdata[159:128];
			end
		end
		if (fin) status_q <= fin_st;
		case (state_q)
			fpea_pkg::S_PREP: begin
				rlen_q <= ({1'b0, len_q} + page_m) & ~page_m;
			end
			fpea_pkg::S_SUM: begin
				sum_q      <= {1'b0, off_q} + {1'b0, len_q};
				endr_q     <= endr_d;
				idx_q      <= '0;
				last_end_q <= '0;
				found_q    <= 1'b0;
			end
			fpea_pkg::S_LOC: begin
				if (!at_count && label_hit) begin
					r_off_q   <= rd.start;
					r_len_q   <= rd.size;
					r_flags_q <= rd.flags;
				end else begin
					idx_q <= idx_inc;
				end
				if (!at_count && label_hit && (cmd_q != fpea_pkg::CMD_FIND)) begin
					r_off_q   <= '0;
					r_len_q   <= '0;
					r_flags_q <= '0;
				end
			end
			fpea_pkg::S_CHECK: begin
				idx_q <= '0;
				pos_q <= count_q;
			end
			fpea_pkg::S_OVL: begin
				if (!at_count && (endr_q <= e_start)) pos_q <= idx_q;
				idx_q <= idx_inc;
			end
			fpea_pkg::S_FINAL:    idx_q <= count_q;
			fpea_pkg::S_SHIFT_UP: idx_q <= idx_dec;
			fpea_pkg::S_SHIFT_DN: idx_q <= idx_inc;
			fpea_pkg::S_GAP: begin
				if (!at_count) begin
					if (gap_ok) begin
						found_q <= 1'b1;
						r_off_q <= at_end_q ? s_minus_need : lo[31:0];
					end
					last_end_q <= e_end;
					idx_q      <= idx_inc;
				end
			end
			fpea_pkg::S_GAP_END: begin
				if (tail_ok) r_off_q <= at_end_q ? fl_minus_need : last_end_q[31:0];
				else if (!found_q) r_off_q <= '0;
			end
			fpea_pkg::S_FREE: begin
				if (at_count) r_off_q <= off_q;
				else idx_q <= idx_inc;
			end
			default: ;
		endcase
		if (resp_go) begin
			m_data_q <= {r_flags_q, r_len_q, r_off_q};
			m_user_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(fpea_pkg::MAX_ENTRIES))
		else $error("entry count beyond table depth");

	// A table that is not valid holds no entries.
	a_empty_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> (count_q == '0))
		else $error("entries present in an invalid table");

	// Once a command transaction is taken, no further one is taken next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("command taken while busy");

	// Table writes land at or below the entry count while an add opens its slot.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && (state_q == fpea_pkg::S_SHIFT_UP)) |-> (32'(wr.idx) <= 32'(count_q)))
		else $error("table write beyond the fill level");

endmodule

`default_nettype wire
